// ----- rtl/spq_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// spq_pkg: shared types for the sorted priority queue
// Field widths, status and action codes, entry and cell control structs.
// ---------------------------------------------------------------------------
package spq_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned PRIO_W  = 16;
    localparam int unsigned OCC_W   = 4;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
    } t_entry;

    typedef struct packed {
        logic   insert;
        logic   remove;
        t_entry entry;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ----- rtl/spq_if.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// spq_req_if / spq_rsp_if: request and response channels
// Valid/ready handshake; a request moves when valid and ready are both high.
// ---------------------------------------------------------------------------
interface spq_req_if import spq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    t_action                   action;
    logic signed [VALUE_W-1:0] value_in;
    logic signed [PRIO_W-1:0]  priority_in;

    modport source (output valid, output action, output value_in, output priority_in,
                    input ready);
    modport sink   (input valid, input action, input value_in, input priority_in,
                    output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    t_status                   status;
    logic signed [VALUE_W-1:0] value_out;
    logic [OCC_W-1:0]          occupancy;

    modport source (output valid, output status, output value_out, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input value_out, input occupancy,
                    output ready);
endinterface
`default_nettype wire

// ----- rtl/spq_cell.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry; on insert keeps, shifts in from the left or takes the new
// entry; on remove shifts in from the right.
// ---------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire logic      i_occ,
    input  wire t_entry    i_left,
    input  wire logic      i_left_occ,
    input  wire logic      i_left_keep,
    input  wire t_entry    i_right,
    output t_entry         o_entry,
    output logic           o_keep
);

    t_entry r_entry;
    t_entry n_entry;

    // Entry stays put when it sorts at or before the new one (ties keep order).
    assign o_keep  = i_occ && (r_entry.prio <= i_ctl.entry.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.insert) begin
            if (o_keep) begin
                n_entry = r_entry;
            end else if (i_left_occ && !i_left_keep) begin
                n_entry = i_left;
            end else begin
                n_entry = i_ctl.entry;
            end
        end else if (i_ctl.remove) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
`default_nettype wire

// ----- rtl/sorted_priority_queue_top.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sorted_priority_queue_top: sorted array priority queue
// DEPTH value/priority pairs in a chain of cells, ascending priority number.
// ---------------------------------------------------------------------------
//  channel  | dir | fields
//  i_req    | in  | action, value_in, priority_in
//  o_rsp    | out | status, value_out, occupancy
//
//  One request per cycle: all cells compare and shift in the same cycle.
//  The response register is refilled while its contents are taken.
//  Synchronous reset empties the store; entry data is not cleared.
//  A stalled response holds back new requests only while it is not taken.
// ---------------------------------------------------------------------------
module sorted_priority_queue_top import spq_pkg::*; #(
    parameter int unsigned DEPTH = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    spq_req_if.sink   i_req,
    spq_rsp_if.source o_rsp
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_status          r_status;
    t_status          n_status;
    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;
    logic [OCC_W-1:0] r_occ;

    logic      w_accept;
    logic      w_full;
    logic      w_empty;
    t_cell_ctl w_ctl;
    t_entry    w_entry [DEPTH];
    logic      w_keep  [DEPTH];
    logic      w_occ   [DEPTH];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_empty     = (r_count == '0);

    assign w_ctl.insert      = w_accept && (i_req.action == ACT_INSERT) && !w_full;
    assign w_ctl.remove      = w_accept && (i_req.action == ACT_REMOVE) && !w_empty;
    assign w_ctl.entry.value = i_req.value_in;
    assign w_ctl.entry.prio  = i_req.priority_in;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign w_occ[g] = (r_count > CNT_W'(g));
        if (g == 0) begin : g_head
            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_occ       (w_occ[g]),
                .i_left      (w_entry[g]),
                .i_left_occ  (1'b0),
                .i_left_keep (1'b0),
                .i_right     (w_entry[(g + 1) % DEPTH]),
                .o_entry     (w_entry[g]),
                .o_keep      (w_keep[g])
            );
        end else begin : g_body
            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_occ       (w_occ[g]),
                .i_left      (w_entry[g-1]),
                .i_left_occ  (w_occ[g-1]),
                .i_left_keep (w_keep[g-1]),
                .i_right     (w_entry[(g + 1) % DEPTH]),
                .o_entry     (w_entry[g]),
                .o_keep      (w_keep[g])
            );
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_value  = '0;
        if (i_req.action == ACT_INSERT) begin
            if (w_full) begin
                n_status = ST_OVERFLOW;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = ST_UNDERFLOW;
            end else begin
                n_count = r_count - CNT_W'(1);
                n_value = w_entry[0].value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_value  <= n_value;
            r_occ    <= OCC_W'(n_count);
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_status;
    assign o_rsp.value_out = r_value;
    assign o_rsp.occupancy = r_occ;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_req.action == ACT_REMOVE) && w_empty
        |=> r_status == ST_UNDERFLOW && r_count == '0)
        else $error("remove from empty store not reported");

    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.insert |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not grow the store");

    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (DEPTH > 1) && w_occ[(1 % DEPTH)] && (r_count > CNT_W'(1))
        |-> w_entry[0].prio <= w_entry[1 % DEPTH].prio)
        else $error("head entries out of order");
`endif

endmodule
`default_nettype wire
